>>> design/bpfl_pkg.sv
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared types, codes and helpers of the buffer pair free list allocator.
// ----------------------------------------------------------------------------
package bpfl_pkg;

    localparam int unsigned BUFFER_COUNT_DEF = 16;
    localparam int unsigned IDX_W            = 4;
    localparam int unsigned RES_W            = 5;
    localparam logic [RES_W-1:0] RESERVE_RESET = 5'd2;

    typedef enum logic [1:0] {
        CMD_PUT      = 2'd0,
        CMD_GET      = 2'd1,
        CMD_GET_PAIR = 2'd2,
        CMD_PUT_PAIR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_DONE     = 2'd0,
        STS_REFUSED  = 2'd1,
        STS_BLOCK    = 2'd2,
        STS_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [IDX_W-1:0] wdata;
    } t_pool_op;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
        logic short;
    } t_pool_flags;

    function automatic t_status pop_status(input t_pool_flags f, input logic w);
        t_status s;
        priority if (w) begin
            s = f.empty ? STS_BLOCK : STS_DONE;
        end else begin
            s = (f.empty || f.short) ? STS_REFUSED : STS_DONE;
        end
        return s;
    endfunction

endpackage

>>> design/bpfl_pool.sv
// ----------------------------------------------------------------------------
// bpfl_pool
// One LIFO free list: stack memory, free count and low-water mark. Entries
// below the low-water mark were never written and read as their own index.
// ----------------------------------------------------------------------------
module bpfl_pool import bpfl_pkg::*; #(
    parameter int unsigned BUFFER_COUNT = BUFFER_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd,
    input  logic [RES_W-1:0] i_reserve,
    input  t_pool_op         i_op,
    output t_pool_flags      o_flags,
    output logic [IDX_W-1:0] o_top
);

    localparam int unsigned AW   = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
    localparam int unsigned CW   = $clog2(BUFFER_COUNT + 1);
    localparam int unsigned CMPW = (CW > RES_W) ? CW : RES_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_COUNT);

    logic [IDX_W-1:0]    mem [BUFFER_COUNT];
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_low, n_low;
    logic [CW-1:0]       top_addr;
    logic [CW+IDX_W-1:0] fresh_ext;
    logic [IDX_W-1:0]    r_mem_q;
    logic [IDX_W-1:0]    r_fresh_val;
    logic                r_fresh;

    assign top_addr  = r_count - CW'(1);
    assign fresh_ext = {{IDX_W{1'b0}}, top_addr};

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            mem[r_count[AW-1:0]] <= i_op.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd && (r_count != '0)) begin
            r_mem_q     <= mem[top_addr[AW-1:0]];
            r_fresh     <= (top_addr < r_low);
            r_fresh_val <= fresh_ext[IDX_W-1:0];
        end
    end

    assign o_top = r_fresh ? r_fresh_val : r_mem_q;

    always_comb begin
        n_count = r_count;
        n_low   = r_low;
        priority if (i_op.push) begin
            n_count = r_count + CW'(1);
        end else if (i_op.pop) begin
            n_count = top_addr;
            if (top_addr < r_low) begin
                n_low = top_addr;
            end
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= FULL_CNT;
            r_low   <= FULL_CNT;
        end else begin
            r_count <= n_count;
            r_low   <= n_low;
        end
    end

    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == FULL_CNT);
    assign o_flags.one   = (r_count == CW'(1));
    assign o_flags.short = (CMPW'(r_count) < CMPW'(i_reserve));

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.push |-> (r_count != FULL_CNT))
        else $error("push onto full pool");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.pop |-> (r_count != '0))
        else $error("pop from empty pool");
    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_count)
        else $error("low-water mark above free count");

endmodule

>>> design/bpfl_ctrl.sv
// ----------------------------------------------------------------------------
// bpfl_ctrl
// Command sequencer: latches the item, decides pops and pushes from the
// pool flags and stack tops, and registers the result.
// ----------------------------------------------------------------------------
module bpfl_ctrl import bpfl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_command,
    input  logic             i_pool_select,
    input  logic             i_wait_req,
    input  logic [IDX_W-1:0] i_desc_index,
    input  logic [IDX_W-1:0] i_data_index,
    output logic             o_rd,
    input  t_pool_flags      i_desc_flags,
    input  t_pool_flags      i_data_flags,
    input  logic [IDX_W-1:0] i_desc_top,
    input  logic [IDX_W-1:0] i_data_top,
    output t_pool_op         o_desc_op,
    output t_pool_op         o_data_op,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_got_desc,
    output logic [IDX_W-1:0] o_got_data,
    output logic             o_wake_desc,
    output logic             o_wake_data
);

    t_state           r_state, n_state;
    t_cmd             r_cmd;
    logic             r_sel, r_wait;
    logic [IDX_W-1:0] r_di, r_ai;

    logic             accept;
    logic             r_valid, n_valid;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_gd, n_gd, r_ga, n_ga;
    logic             r_wd, n_wd, r_wa, n_wa;

    t_pool_flags      sel_flags;
    logic [IDX_W-1:0] sel_top;
    t_status          st_d, st_a, st_sel;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_rd   = accept;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_command);
            r_sel  <= i_pool_select;
            r_wait <= i_wait_req;
            r_di   <= i_desc_index;
            r_ai   <= i_data_index;
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign sel_flags = r_sel ? i_data_flags : i_desc_flags;
    assign sel_top   = r_sel ? i_data_top : i_desc_top;
    assign st_d      = pop_status(i_desc_flags, r_wait);
    assign st_a      = pop_status(i_data_flags, r_wait);
    assign st_sel    = pop_status(sel_flags, r_wait);

    always_comb begin
        o_desc_op = '0;
        o_data_op = '0;
        n_valid   = 1'b0;
        n_status  = STS_DONE;
        n_gd      = '0;
        n_ga      = '0;
        n_wd      = 1'b0;
        n_wa      = 1'b0;
        if (r_state == S_EXEC) begin
            n_valid = 1'b1;
            unique case (r_cmd)
                CMD_PUT: begin
                    if (sel_flags.full) begin
                        n_status = STS_OVERFLOW;
                    end else if (r_sel) begin
                        o_data_op.push  = 1'b1;
                        o_data_op.wdata = r_di;
                        n_wa            = sel_flags.empty;
                    end else begin
                        o_desc_op.push  = 1'b1;
                        o_desc_op.wdata = r_di;
                        n_wd            = sel_flags.empty;
                    end
                end
                CMD_GET: begin
                    n_status = st_sel;
                    if (st_sel == STS_DONE) begin
                        n_gd = sel_top;
                        if (r_sel) begin
                            o_data_op.pop = 1'b1;
                        end else begin
                            o_desc_op.pop = 1'b1;
                        end
                    end
                end
                CMD_GET_PAIR: begin
                    priority if (st_d != STS_DONE) begin
                        n_status = st_d;
                    end else if (st_a != STS_DONE) begin
                        // descriptor is not taken; wake is flagged if only one descriptor is free
                        n_status = st_a;
                        n_wd     = i_desc_flags.one;
                    end else begin
                        o_desc_op.pop = 1'b1;
                        o_data_op.pop = 1'b1;
                        n_gd          = i_desc_top;
                        n_ga          = i_data_top;
                    end
                end
                CMD_PUT_PAIR: begin
                    if (!i_data_flags.full) begin
                        o_data_op.push  = 1'b1;
                        o_data_op.wdata = r_ai;
                        n_wa            = i_data_flags.empty;
                    end
                    if (!i_desc_flags.full) begin
                        o_desc_op.push  = 1'b1;
                        o_desc_op.wdata = r_di;
                        n_wd            = i_desc_flags.empty;
                    end
                    if (i_data_flags.full || i_desc_flags.full) begin
                        n_status = STS_OVERFLOW;
                    end
                end
                default: n_status = STS_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_gd     <= n_gd;
        r_ga     <= n_ga;
        r_wd     <= n_wd;
        r_wa     <= n_wa;
    end

    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_got_desc     = r_gd;
    assign o_got_data     = r_ga;
    assign o_wake_desc    = r_wd;
    assign o_wake_data    = r_wa;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("no execute cycle after accepted item");
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without execute cycle");

endmodule

>>> design/buffer_pair_free_list_allocator.sv
// ----------------------------------------------------------------------------
// buffer_pair_free_list_allocator
// Two LIFO free lists (descriptors, data buffers) with put, get, get_pair
// and put_pair commands, reserve check and empty-to-non-empty wakeups.
// ----------------------------------------------------------------------------
// The item is latched on accept and decided in the execute state; the result
// is registered from there. No new item is taken while busy: the stack top is
// read from synchronous memory on accept and written back in the execute state.
// Reset: both pools full with entry i holding i, reserve level 2; no clearing
// pass, a low-water mark stands in for the reset contents of each stack.
// Results cannot be stalled by the receiver.
module buffer_pair_free_list_allocator import bpfl_pkg::*; #(
    parameter int unsigned BUFFER_COUNT = BUFFER_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_command,
    input  logic             i_pool_select,
    input  logic             i_wait_req,
    input  logic [IDX_W-1:0] i_desc_index,
    input  logic [IDX_W-1:0] i_data_index,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [RES_W-1:0] i_cfg_data,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_got_desc,
    output logic [IDX_W-1:0] o_got_data,
    output logic             o_wake_desc,
    output logic             o_wake_data
);

    logic [RES_W-1:0] r_reserve;
    logic             rd;
    t_pool_flags      desc_flags, data_flags;
    logic [IDX_W-1:0] desc_top, data_top;
    t_pool_op         desc_op, data_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserve <= RESERVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_reserve <= i_cfg_data;
        end
    end

    bpfl_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_pool_select  (i_pool_select),
        .i_wait_req     (i_wait_req),
        .i_desc_index   (i_desc_index),
        .i_data_index   (i_data_index),
        .o_rd           (rd),
        .i_desc_flags   (desc_flags),
        .i_data_flags   (data_flags),
        .i_desc_top     (desc_top),
        .i_data_top     (data_top),
        .o_desc_op      (desc_op),
        .o_data_op      (data_op),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_got_desc     (o_got_desc),
        .o_got_data     (o_got_data),
        .o_wake_desc    (o_wake_desc),
        .o_wake_data    (o_wake_data)
    );

    bpfl_pool #(.BUFFER_COUNT(BUFFER_COUNT)) u_desc_pool (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd),
        .i_reserve (r_reserve),
        .i_op      (desc_op),
        .o_flags   (desc_flags),
        .o_top     (desc_top)
    );

    bpfl_pool #(.BUFFER_COUNT(BUFFER_COUNT)) u_data_pool (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd),
        .i_reserve (r_reserve),
        .i_op      (data_op),
        .o_flags   (data_flags),
        .o_top     (data_top)
    );

endmodule
